### sv/single_wire_led_bit_encoder_assert.svh
// Assertion macros shared by the LED bit encoder modules.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef SINGLE_WIRE_LED_BIT_ENCODER_ASSERT_SVH
`define SINGLE_WIRE_LED_BIT_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slbe check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define SLBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slbe check failed: next-cycle implication");

`endif

### sv/slbe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the single-wire LED bit encoder.
// No dependencies; imported by every module of the block.
package slbe_pkg;

  localparam int FRAME_BITS_DEF = 24;
  localparam int COLOR_W        = 24;
  localparam int CFG_W          = 8;
  localparam int CFG_IDX_W      = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_HIGH  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] PERIOD_LEN_RST = 8'd120;
  localparam logic [CFG_W-1:0] SHORT_HIGH_RST = 8'd30;
  localparam logic [CFG_W-1:0] LONG_HIGH_RST  = 8'd90;

  // Command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [COLOR_W-1:0] color_word;
  } in_fields_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic load_accepted;
  } out_fields_t;

  typedef struct packed {
    logic [CFG_W-1:0] period_len;
    logic [CFG_W-1:0] short_high;
    logic [CFG_W-1:0] long_high;
  } cfg_t;

endpackage

### sv/slbe_cfg_regs.sv
`timescale 1ns / 1ps
// Timing configuration registers of the LED bit encoder.
// Depends on slbe_pkg.
module slbe_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [slbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slbe_pkg::CFG_W-1:0]      cfg_wdata,
  output slbe_pkg::cfg_t                  cfg
);
  import slbe_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD_LEN: cfg_nxt.period_len = cfg_wdata;
        REG_SHORT_HIGH: cfg_nxt.short_high = cfg_wdata;
        REG_LONG_HIGH:  cfg_nxt.long_high  = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_len <= PERIOD_LEN_RST;
      cfg_r.short_high <= SHORT_HIGH_RST;
      cfg_r.long_high  <= LONG_HIGH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/slbe_core.sv
`timescale 1ns / 1ps
// Frame state and waveform logic: one beat in, one result out, same cycle.
// Depends on slbe_pkg and the assertion macro header.
`include "single_wire_led_bit_encoder_assert.svh"
module slbe_core #(
  parameter int FRAME_BITS = slbe_pkg::FRAME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  slbe_pkg::in_fields_t     in_item,
  input  slbe_pkg::cfg_t           cfg,
  output slbe_pkg::out_fields_t    result
);
  import slbe_pkg::*;

  localparam int BL_W = $clog2(FRAME_BITS + 1);

  logic                  sending_r, sending_nxt;
  logic                  lead_r, lead_nxt;
  logic [BL_W-1:0]       bits_left_r, bits_left_nxt;
  logic [CFG_W-1:0]      tick_r, tick_nxt;
  logic [FRAME_BITS-1:0] shifter_r, shifter_nxt;

  logic [COLOR_W+31:0]   word_ext;
  logic [CFG_W-1:0]      high_ticks;
  logic                  period_end;
  logic [BL_W-1:0]       bits_dec;

  // Words wider than the colour field are padded with zeros above it.
  assign word_ext   = {32'd0, in_item.color_word};
  assign high_ticks = shifter_r[FRAME_BITS-1] ? cfg.long_high : cfg.short_high;
  assign period_end = ({1'b0, tick_r} + 9'd1) >= {1'b0, cfg.period_len};
  assign bits_dec   = (bits_left_r != '0) ? bits_left_r - BL_W'(1) : '0;

  always_comb begin
    sending_nxt   = sending_r;
    lead_nxt      = lead_r;
    bits_left_nxt = bits_left_r;
    tick_nxt      = tick_r;
    shifter_nxt   = shifter_r;
    result        = '0;
    if (in_item.cmd == CMD_LOAD) begin
      if (!sending_r) begin
        sending_nxt          = 1'b1;
        lead_nxt             = 1'b1;
        bits_left_nxt        = BL_W'(FRAME_BITS);
        tick_nxt             = '0;
        shifter_nxt          = word_ext[FRAME_BITS-1:0];
        result.load_accepted = 1'b1;
      end
      result.busy_res = 1'b1;
    end else if (sending_r) begin
      result.busy_res = 1'b1;
      if (!lead_r) begin
        result.line_level = tick_r < high_ticks;
      end
      if (period_end) begin
        tick_nxt = '0;
        if (lead_r) begin
          lead_nxt = 1'b0;
        end else begin
          shifter_nxt   = shifter_r << 1;
          bits_left_nxt = bits_dec;
          if (bits_dec == '0) begin
            sending_nxt       = 1'b0;
            result.frame_done = 1'b1;
          end
        end
      end else begin
        tick_nxt = tick_r + CFG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r   <= 1'b0;
      lead_r      <= 1'b0;
      bits_left_r <= '0;
      tick_r      <= '0;
      shifter_r   <= '0;
    end else if (accept) begin
      sending_r   <= sending_nxt;
      lead_r      <= lead_nxt;
      bits_left_r <= bits_left_nxt;
      tick_r      <= tick_nxt;
      shifter_r   <= shifter_nxt;
    end
  end

  `SLBE_ASSERT_NOW(a_done_while_busy, clk, rst_n, result.frame_done, result.busy_res)
  `SLBE_ASSERT_NOW(a_done_ends_frame, clk, rst_n, accept && result.frame_done,
                   sending_r && !lead_r && bits_left_r == BL_W'(1))
  `SLBE_ASSERT_NEXT(a_load_starts_lead, clk, rst_n, accept && result.load_accepted,
                    sending_r && lead_r && tick_r == '0)

endmodule

### sv/slbe_out_buf.sv
`timescale 1ns / 1ps
// Result register with a skid stage, so a beat can enter while one waits.
// Depends on slbe_pkg and the assertion macro header.
`include "single_wire_led_bit_encoder_assert.svh"
module slbe_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  slbe_pkg::out_fields_t  push_data,
  output logic                   push_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output slbe_pkg::out_fields_t  out_data
);
  import slbe_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  out_fields_t out_data_r, out_data_nxt;
  out_fields_t skid_data_r, skid_data_nxt;
  logic        pop;

  assign pop        = out_valid_r && out_ready;
  assign push_ready = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_data_nxt = push_data;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SLBE_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `SLBE_ASSERT_NOW(a_no_push_when_full, clk, rst_n, skid_valid_r, !push)
  `SLBE_ASSERT_NEXT(a_skid_moves_up, clk, rst_n, pop && skid_valid_r,
                    out_valid_r && out_data_r == $past(skid_data_r))

endmodule

### sv/single_wire_led_bit_encoder.sv
`timescale 1ns / 1ps
// Top level of the single-wire LED bit encoder.
// Depends on slbe_pkg, slbe_cfg_regs, slbe_core and slbe_out_buf.
//
//   Port group  Direction  Handshake           Payload
//   in_         input      in_valid/in_ready   in_fields_t (cmd, color_word)
//   out_        output     out_valid/out_ready out_fields_t (level, busy, done, accepted)
//   cfg_        input      cfg_we              cfg_index, cfg_wdata
//
// Each beat is handled combinationally; its result is registered before it shows on out_data.
// A new beat is taken every cycle while the skid stage is empty.
// When the output stalls, one further beat lands in the skid stage, then in_ready drops.
// Reset is synchronous and active low; it restores the timing registers to their defaults.
module single_wire_led_bit_encoder #(
  parameter int FRAME_BITS = slbe_pkg::FRAME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  slbe_pkg::in_fields_t            in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output slbe_pkg::out_fields_t           out_data,
  input  logic                            cfg_we,
  input  logic [slbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slbe_pkg::CFG_W-1:0]      cfg_wdata
);
  import slbe_pkg::*;

  cfg_t        cfg;
  out_fields_t result;
  logic        accept;

  assign accept = in_valid && in_ready;

  slbe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  slbe_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .cfg     (cfg),
    .result  (result)
  );

  slbe_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (result),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
